[design/ism_pkg.sv]
// ism_pkg: shared types and constants of the input sequence matcher
// no dependencies; used by ism_cell, ism_row and input_sequence_matcher
package ism_pkg;

  // default geometry
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int PATTERN_COUNT_DEF = 8;
  localparam int CODE_WIDTH_DEF    = 16;

  // fixed field widths of the stream beats
  localparam int PAD_CODE_W  = 16;
  localparam int SLOT_W      = 3;
  localparam int POS_W       = 4;
  localparam int ID_W        = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic {
    KIND_PRESS = 1'b0,
    KIND_LOAD  = 1'b1
  } ism_kind_e;

  // history cell control
  typedef struct packed {
    logic shift;
    logic clear;
  } ism_cell_ctrl_t;

  // pattern row compare control
  typedef struct packed {
    logic start;
    logic step;
  } ism_scan_ctrl_t;

endpackage

[design/ism_cell.sv]
// ism_cell: one history entry of the shift chain
// depends on ism_pkg
module ism_cell #(
  parameter int CODE_WIDTH = ism_pkg::CODE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ism_pkg::ism_cell_ctrl_t ctrl_i,
  input  logic [CODE_WIDTH-1:0] d_i,
  output logic [CODE_WIDTH-1:0] q_o
);
  import ism_pkg::*;

  logic [CODE_WIDTH-1:0] code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else if (ctrl_i.clear) begin
      code_q <= '0;
    end else if (ctrl_i.shift) begin
      code_q <= d_i;
    end
  end

  assign q_o = code_q;

endmodule

[design/ism_row.sv]
// ism_row: one stored sequence, its length and its running compare
// depends on ism_pkg
module ism_row #(
  parameter int HISTORY_DEPTH = ism_pkg::HISTORY_DEPTH_DEF,
  parameter int CODE_WIDTH    = ism_pkg::CODE_WIDTH_DEF,
  localparam int TW = $clog2(HISTORY_DEPTH),
  localparam int LW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [TW-1:0]           wr_idx_i,
  input  logic [CODE_WIDTH-1:0]   wr_data_i,
  input  ism_pkg::ism_scan_ctrl_t scan_i,
  input  logic [TW-1:0]           tick_i,
  input  logic [CODE_WIDTH-1:0]   tap_i,
  output logic                    hit_o
);
  import ism_pkg::*;

  localparam int SW = LW + 1;

  logic [CODE_WIDTH-1:0] word_q [HISTORY_DEPTH];
  logic                  ok_q;
  logic [LW-1:0]         len;
  logic [SW-1:0]         sum;
  logic                  in_win;
  logic [TW-1:0]         elem_idx;
  logic                  bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) word_q[k] <= '0;
    end else if (wr_en_i) begin
      word_q[wr_idx_i] <= wr_data_i;
    end
  end

  // leading nonzero words
  always_comb begin
    logic run;
    run = 1'b1;
    len = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (run && (word_q[k] != '0)) begin
        len = LW'(k + 1);
      end else begin
        run = 1'b0;
      end
    end
  end

  // the tap walks the history newest-last; element tick+len-depth lines up with it
  assign sum      = SW'(tick_i) + SW'(len);
  assign in_win   = (sum >= SW'(HISTORY_DEPTH));
  assign elem_idx = TW'(sum - SW'(HISTORY_DEPTH));
  assign bad      = in_win && (word_q[elem_idx] != tap_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (scan_i.start) begin
      ok_q <= 1'b1;
    end else if (scan_i.step && bad) begin
      ok_q <= 1'b0;
    end
  end

  assign hit_o = ok_q && (len != '0);

endmodule

[design/input_sequence_matcher.sv]
// input_sequence_matcher: detects stored button sequences in the recent press history
// depends on ism_pkg, ism_cell and ism_row
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_axis   | in  | pad_code[15:0] loading_active[16] slot[19:17]   | kind
//           |     | position[23:20]                                 |
//  m_axis   | out | pattern_id[2:0], zero fill [7:3]                | matched
//
// a table write or an ignored press gives its result in the cycle after the beat
// a counted press gives its result once the history chain has rotated through its
// HISTORY_DEPTH cells past the compare tap and the done state has picked the winner;
// the next beat can be taken once the matcher is back in idle at the earliest
// one beat is worked on at a time; s_axis_tready_o waits while the result register is held
// reset clears history and the pattern table at once, no sweep
module input_sequence_matcher #(
  parameter int HISTORY_DEPTH = ism_pkg::HISTORY_DEPTH_DEF,
  parameter int PATTERN_COUNT = ism_pkg::PATTERN_COUNT_DEF,
  parameter int CODE_WIDTH    = ism_pkg::CODE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // pad_code, loading_active, pattern_slot, pattern_position
  input  logic [ism_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // kind
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // pattern_id, zero fill
  output logic [ism_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // matched
  output logic                           m_axis_tuser_o
);
  import ism_pkg::*;

  localparam int TW      = $clog2(HISTORY_DEPTH);
  localparam int KeepW   = (CODE_WIDTH < PAD_CODE_W) ? CODE_WIDTH : PAD_CODE_W;
  localparam int PosKeep = (TW < POS_W) ? TW : POS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [TW-1:0]     tick_q;
  logic              out_valid_q;
  logic              out_matched_q;
  logic [ID_W-1:0]   out_id_q;

  logic [PAD_CODE_W-1:0] pad_code;
  logic                  loading;
  logic [SLOT_W-1:0]     slot;
  logic [POS_W-1:0]      pos;
  ism_kind_e             kind;
  logic [CODE_WIDTH-1:0] code;
  logic [TW-1:0]         wr_idx;
  logic                  wr_ok;

  logic accept;
  logic do_load;
  logic do_push;
  logic do_ignore;
  logic found;
  logic [ID_W-1:0] found_id;

  logic [CODE_WIDTH-1:0] hist [HISTORY_DEPTH];
  logic [CODE_WIDTH-1:0] head_d;
  ism_cell_ctrl_t        cell_ctrl;
  ism_scan_ctrl_t        scan_ctrl;
  logic [PATTERN_COUNT-1:0] hit;

  assign pad_code = s_axis_tdata_i[15:0];
  assign loading  = s_axis_tdata_i[16];
  assign slot     = s_axis_tdata_i[19:17];
  assign pos      = s_axis_tdata_i[23:20];
  assign kind     = ism_kind_e'(s_axis_tuser_i);

  assign code   = CODE_WIDTH'(pad_code[KeepW-1:0]);
  assign wr_idx = TW'(pos[PosKeep-1:0]);
  assign wr_ok  = (32'(pos) < HISTORY_DEPTH) && (32'(slot) < PATTERN_COUNT);

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign do_load   = accept && (kind == KIND_LOAD);
  assign do_push   = accept && (kind == KIND_PRESS) && !loading && (code != '0);
  assign do_ignore = accept && !do_load && !do_push;

  // push shifts the new code in; the scan rotates the chain back onto itself
  assign head_d          = do_push ? code : hist[HISTORY_DEPTH-1];
  assign cell_ctrl.shift = do_push || (state_q == ST_SCAN);
  assign cell_ctrl.clear = (state_q == ST_DONE) && found;
  assign scan_ctrl.start = do_push;
  assign scan_ctrl.step  = (state_q == ST_SCAN);

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    logic [CODE_WIDTH-1:0] cell_d;
    if (k == 0) begin : g_head
      assign cell_d = head_d;
    end else begin : g_link
      assign cell_d = hist[k-1];
    end
    ism_cell #(
      .CODE_WIDTH(CODE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .d_i    (cell_d),
      .q_o    (hist[k])
    );
  end

  for (genvar r = 0; r < PATTERN_COUNT; r++) begin : g_row
    logic row_wr;
    assign row_wr = do_load && wr_ok && (32'(slot) == r);
    ism_row #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .CODE_WIDTH   (CODE_WIDTH)
    ) u_row (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (row_wr),
      .wr_idx_i  (wr_idx),
      .wr_data_i (code),
      .scan_i    (scan_ctrl),
      .tick_i    (tick_q),
      .tap_i     (hist[HISTORY_DEPTH-1]),
      .hit_o     (hit[r])
    );
  end

  // lowest-numbered hit wins
  always_comb begin
    found    = 1'b0;
    found_id = '0;
    for (int r = PATTERN_COUNT - 1; r >= 0; r--) begin
      if (hit[r]) begin
        found    = 1'b1;
        found_id = ID_W'(r);
      end
    end
  end

  // the result register can only be full while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tick_q        <= '0;
      out_valid_q   <= 1'b0;
      out_matched_q <= 1'b0;
      out_id_q      <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (do_load || do_ignore) begin
            out_valid_q   <= 1'b1;
            out_matched_q <= 1'b0;
            out_id_q      <= '0;
          end else begin
            if (out_valid_q && m_axis_tready_i) begin
              out_valid_q <= 1'b0;
            end
            if (do_push) begin
              tick_q  <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (tick_q == TW'(HISTORY_DEPTH - 1)) begin
            state_q <= ST_DONE;
          end else begin
            tick_q <= tick_q + 1'b1;
          end
        end
        ST_DONE: begin
          out_valid_q   <= 1'b1;
          out_matched_q <= found;
          out_id_q      <= found_id;
          state_q       <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_matched_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_id_q);

endmodule
